// File: sv/tmtw_pkg.sv
// shared types, codes and constants of the text mode terminal writer
package tmtw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam logic [7:0] NEWLINE_CODE      = 8'd10;
	localparam logic [7:0] SPACE_CODE        = 8'h20;
	localparam logic [7:0] RESET_COLOR       = 8'h07;
	localparam logic       RESET_AUTOSCROLL  = 1'b1;
	localparam int         AUTO_SCROLL_LINES = 2;

	// operation codes
	localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
	localparam logic [2:0] OP_PUT_BYTE   = 3'd1;
	localparam logic [2:0] OP_BACKSPACE  = 3'd2;
	localparam logic [2:0] OP_GO_TO      = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;
	localparam logic [2:0] OP_READ_CELL  = 3'd5;
	localparam logic [2:0] OP_WRITE_CELL = 3'd6;
	localparam logic [2:0] OP_SCROLL     = 3'd7;

	// configuration register indexes
	localparam int         CFG_IDX_W      = 1;
	localparam logic [0:0] CFG_TEXT_COLOR = 1'b0;
	localparam logic [0:0] CFG_AUTOSCROLL = 1'b1;

	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  char_code;
		logic [15:0] cell_value;
		logic [7:0]  target_col;
		logic [7:0]  target_row;
		logic [4:0]  scroll_lines;
	} in_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_linear;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic exec;
		logic boot;
		logic sweep_step;
		logic read_capture;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_req;
		logic read_req;
		logic sweep_done;
	} sts_t;

endpackage

// File: sv/text_mode_terminal_writer.sv
// top level of the character-cell text mode terminal writer
//
// usage
//   input channel (in_valid/in_ready/in_data): one operation per transaction,
//     put_char, put_byte, backspace, go_to, clear, read_cell, write_cell, scroll
//   output channel (out_valid/out_ready/out_data): exactly one result per
//     operation, in order: read value (zero unless read_cell) and the cursor
//     after the operation, also as row * COLUMNS + column
//   configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
//     ready; index 0 is the text colour, index 1 the autoscroll enable
// timing
//   cursor moves, character writes and single cell writes: accept, execute and load the result
//   read_cell: accept, execute, then the read state captures the registered
//     store read and the finish state passes it on to the output register
//   clear, scroll and an autoscroll on bottom overflow: the sweep copies or
//     blanks one cell per cycle through the single read and single write
//     port of the cell store
// reset
//   cursor to the origin, colour 7, autoscroll on; then a clearing pass fills
//   the store with blank cells, during which in_ready stays low and
//   configuration writes are still taken
// stalls
//   a result waits in the output register; the next item is still taken and
//   worked on, and its result is held back until the waiting one is taken
module text_mode_terminal_writer
	import tmtw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// sequencing: accept, execute, optional read or sweep, result hand-off
	tmtw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// cursor, colour, cell store and the copy and blank sweep
	tmtw_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_data (out_data)
	);

endmodule

// File: sv/tmtw_ram.sv
// generic single write port, single read port ram with registered read
module tmtw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/tmtw_datapath.sv
// cursor, configuration, cell store and sweep engine of the terminal writer
module tmtw_datapath
	import tmtw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  in_t                  in_data,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output out_t                 out_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int CLW   = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int NW    = $clog2(ROWS + 1);

	localparam logic [CLW-1:0] LAST_COL = CLW'(COLUMNS - 1);
	localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0]  CELLS_C  = CW'(CELLS);

	in_t            item_q;
	logic [CLW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic [7:0]     color_q;
	logic           auto_q;
	logic [15:0]    readv_q;
	out_t           out_q;

	// sweep engine
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  off_q;
	logic [CW-1:0]  lim_q;
	logic [15:0]    blank_q;
	logic           pend_s1;
	logic [AW-1:0]  waddr_s1;
	logic           wblank_s1;

	// operation decode
	logic [CLW-1:0] col_d;
	logic [RW-1:0]  row_d;
	logic           ex_we;
	logic           ex_re;
	logic [15:0]    ex_wdata;
	logic [7:0]     a_col;
	logic [7:0]     a_row;
	logic           put;
	logic           nl;
	logic           sweep_req;
	logic [NW-1:0]  sweep_n;
	logic           tgt_ok;
	logic [15:0]    addr_full;
	logic [AW-1:0]  ex_addr;
	logic [CW-1:0]  off_d;
	logic [CW-1:0]  lim_d;
	logic [15:0]    cur_blank;

	// store ports
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [15:0]    ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [15:0]    ram_rdata;
	logic           sw_re;
	logic [CW-1:0]  sw_sum;
	logic [AW-1:0]  sw_raddr;

	// result
	logic [CLW-1:0] o_col;
	logic [RW-1:0]  o_row;
	logic [15:0]    lin_full;
	out_t           out_d;

	assign cur_blank = {color_q, SPACE_CODE};
	assign tgt_ok    = ({1'b0, item_q.target_col} < 9'(COLUMNS)) &&
		({1'b0, item_q.target_row} < 9'(ROWS));

	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		ex_we     = 1'b0;
		ex_re     = 1'b0;
		ex_wdata  = {color_q, item_q.char_code};
		a_col     = 8'(col_q);
		a_row     = 8'(row_q);
		put       = 1'b0;
		nl        = 1'b0;
		sweep_req = 1'b0;
		sweep_n   = NW'(ROWS);
		unique case (item_q.operation)
			OP_PUT_CHAR: begin
				if (item_q.char_code == NEWLINE_CODE) begin
					nl = 1'b1;
				end else begin
					put = 1'b1;
				end
			end
			OP_PUT_BYTE: begin
				put = 1'b1;
			end
			OP_BACKSPACE: begin
				if (col_q != '0 || row_q != '0) begin
					if (col_q == '0) begin
						row_d = row_q - 1'b1;
						col_d = LAST_COL;
					end else begin
						col_d = col_q - 1'b1;
					end
					ex_we    = 1'b1;
					ex_wdata = cur_blank;
					a_col    = 8'(col_d);
					a_row    = 8'(row_d);
				end
			end
			OP_GO_TO: begin
				col_d = ({1'b0, item_q.target_col} >= 9'(COLUMNS)) ? LAST_COL :
					CLW'(item_q.target_col);
				row_d = ({1'b0, item_q.target_row} >= 9'(ROWS)) ? LAST_ROW :
					RW'(item_q.target_row);
			end
			OP_CLEAR: begin
				sweep_req = 1'b1;
				sweep_n   = NW'(ROWS);
			end
			OP_READ_CELL: begin
				a_col = item_q.target_col;
				a_row = item_q.target_row;
				ex_re = tgt_ok;
			end
			OP_WRITE_CELL: begin
				a_col    = item_q.target_col;
				a_row    = item_q.target_row;
				ex_we    = tgt_ok;
				ex_wdata = item_q.cell_value;
			end
			OP_SCROLL: begin
				sweep_n   = ({2'b00, item_q.scroll_lines} >= 7'(ROWS)) ? NW'(ROWS) :
					NW'(item_q.scroll_lines);
				sweep_req = (sweep_n != '0);
				row_d     = (NW'(row_q) >= sweep_n) ? RW'(NW'(row_q) - sweep_n) : '0;
			end
			default: ;
		endcase

		if (put) begin
			ex_we = 1'b1;
			if (col_q == LAST_COL) begin
				nl = 1'b1;
			end else begin
				col_d = col_q + 1'b1;
			end
		end

		// newline, with bottom overflow
		if (nl) begin
			col_d = '0;
			if (row_q == LAST_ROW) begin
				if (auto_q) begin
					row_d     = RW'(ROWS - AUTO_SCROLL_LINES);
					sweep_req = 1'b1;
					sweep_n   = NW'(AUTO_SCROLL_LINES);
				end else begin
					row_d = '0;
				end
			end else begin
				row_d = row_q + 1'b1;
			end
		end
	end

	assign addr_full = 16'(a_row) * 16'(COLUMNS) + 16'(a_col);
	assign ex_addr   = addr_full[AW-1:0];
	assign off_d     = CW'(32'(sweep_n) * COLUMNS);
	assign lim_d     = CELLS_C - off_d;

	assign sts.sweep_req  = sweep_req;
	assign sts.read_req   = ex_re;
	assign sts.sweep_done = (cnt_q == CELLS_C);

	// registered item and configuration
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_COLOR;
			auto_q  <= RESET_AUTOSCROLL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TEXT_COLOR: color_q <= cfg_data;
				CFG_AUTOSCROLL: auto_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.exec) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			readv_q <= '0;
		end else if (cmd.read_capture) begin
			readv_q <= ram_rdata;
		end
	end

	// sweep: reads run one entry ahead of the copy writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			off_q <= '0;
			lim_q <= '0;
		end else if (cmd.boot) begin
			cnt_q <= '0;
			off_q <= '0;
			lim_q <= '0;
		end else if (cmd.exec && sweep_req) begin
			cnt_q <= '0;
			off_q <= off_d;
			lim_q <= lim_d;
		end else if (cmd.sweep_step && cnt_q != CELLS_C) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.boot) begin
			blank_q <= {RESET_COLOR, SPACE_CODE};
		end else if (cmd.exec && sweep_req) begin
			blank_q <= cur_blank;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= cmd.sweep_step && (cnt_q != CELLS_C);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1  <= cnt_q[AW-1:0];
		wblank_s1 <= (cnt_q >= lim_q);
	end

	assign sw_re    = cmd.sweep_step && (cnt_q < lim_q);
	assign sw_sum   = cnt_q + off_q;
	assign sw_raddr = sw_sum[AW-1:0];

	// store ports: sweep traffic and single accesses never overlap
	assign ram_we    = pend_s1 || (cmd.exec && ex_we);
	assign ram_waddr = pend_s1 ? waddr_s1 : ex_addr;
	assign ram_wdata = pend_s1 ? (wblank_s1 ? blank_q : ram_rdata) : ex_wdata;
	assign ram_re    = sw_re || (cmd.exec && ex_re);
	assign ram_raddr = cmd.sweep_step ? sw_raddr : ex_addr;

	tmtw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// result: straight from the update when loaded during execution
	assign o_col    = cmd.exec ? col_d : col_q;
	assign o_row    = cmd.exec ? row_d : row_q;
	assign lin_full = 16'(o_row) * 16'(COLUMNS) + 16'(o_col);

	always_comb begin
		out_d.read_value    = cmd.exec ? 16'h0000 : readv_q;
		out_d.cursor_col    = 7'(o_col);
		out_d.cursor_row    = 5'(o_row);
		out_d.cursor_linear = lin_full[10:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	assign out_data = out_q;

endmodule

// File: sv/tmtw_ctrl.sv
// controller state machine of the terminal writer
module tmtw_ctrl
	import tmtw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_BOOT   = 7'b0000001,
		ST_INIT   = 7'b0000010,
		ST_IDLE   = 7'b0000100,
		ST_EXEC   = 7'b0001000,
		ST_READ   = 7'b0010000,
		ST_SWEEP  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_BOOT: begin
				cmd.boot = 1'b1;
				state_d  = ST_INIT;
			end
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				priority if (sts.read_req) begin
					state_d = ST_READ;
				end else if (sts.sweep_req) begin
					state_d = ST_SWEEP;
				end else if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_READ: begin
				cmd.read_capture = 1'b1;
				state_d          = ST_FINISH;
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_BOOT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BOOT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: sv/tmtw_checker.sv
// port level checks of the terminal writer and their binding
module tmtw_checker
	import tmtw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	// an accepted item is worked on before the next is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
	else $error("input taken while an item is in progress");

	// a new result only follows a working state, in which the input is not ready
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
	else $error("result appeared without a working cycle");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(out_data.cursor_col) < COLUMNS) &&
			(32'(out_data.cursor_row) < ROWS))
	else $error("cursor outside the screen");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
	else $error("stalled result changed or dropped");

endmodule

bind text_mode_terminal_writer tmtw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
